// ===== rtl/fcb_pkg.sv =====
// Shared types and constants for the FIR convolver with one block of latency.
// Holds the request structs, the controller state type and the cell control group.
// No dependencies.
package fcb_pkg;

    localparam int DATA_W     = 16;
    localparam int COEF_IDX_W = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int TAPCNT_W   = 9;
    localparam int SCALE_W    = 16;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int SCALED_W   = PROD_W + SCALE_W + 1;
    localparam int OUT_SHIFT  = 27;

    localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_GAIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE     = 2'd2;

    localparam logic OP_FEED = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    localparam logic [TAPCNT_W-1:0] TAP_COUNT_RST = 9'd256;
    localparam logic [SCALE_W-1:0]  SCALE_RST     = 16'd4096;
    localparam logic                ENABLE_RST    = 1'b1;

    localparam logic signed [DATA_W-1:0] SAT_MAX = 16'sh7fff;
    localparam logic signed [DATA_W-1:0] SAT_MIN = 16'sh8000;

    typedef struct packed {
        logic                     opcode;
        logic signed [15:0]       sample;
        logic [COEF_IDX_W-1:0]    coef_index;
        logic signed [15:0]       coef_value;
    } t_in_req;

    typedef struct packed {
        logic signed [15:0] out_sample;
        logic               saturated;
    } t_out_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SKIP,
        ST_MAC,
        ST_DRAIN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic shift_line;
        logic clear_line;
        logic load_win;
        logic shift_win;
        logic shift_rot;
    } t_cell_ctrl;

endpackage

// ===== rtl/fcb_cell.sv =====
// One tap cell of the convolver chain: coefficient, two history entries and
// their working copies, each handed to a neighbor cell. Depends on fcb_pkg.
module fcb_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  fcb_pkg::t_cell_ctrl        i_ctrl,
    input  logic                       i_coef_we,
    input  logic signed [15:0]         i_coef_value,
    input  logic signed [15:0]         i_line_a,
    input  logic signed [15:0]         i_line_b,
    input  logic signed [15:0]         i_win_a,
    input  logic signed [15:0]         i_win_b,
    input  logic signed [15:0]         i_rot,
    output logic signed [15:0]         o_line_a,
    output logic signed [15:0]         o_line_b,
    output logic signed [15:0]         o_win_a,
    output logic signed [15:0]         o_win_b,
    output logic signed [15:0]         o_rot
);
    import fcb_pkg::*;

    logic signed [DATA_W-1:0] r_coef;
    logic signed [DATA_W-1:0] r_line_a;
    logic signed [DATA_W-1:0] r_line_b;
    logic signed [DATA_W-1:0] r_win_a;
    logic signed [DATA_W-1:0] r_win_b;
    logic signed [DATA_W-1:0] r_rot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef   <= '0;
            r_line_a <= '0;
            r_line_b <= '0;
        end else begin
            if (i_coef_we) begin
                r_coef <= i_coef_value;
            end
            if (i_ctrl.clear_line) begin
                r_line_a <= '0;
                r_line_b <= '0;
            end else if (i_ctrl.shift_line) begin
                r_line_a <= i_line_a;
                r_line_b <= i_line_b;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_win) begin
            r_win_a <= i_line_a;
            r_win_b <= i_line_b;
            r_rot   <= r_coef;
        end else begin
            if (i_ctrl.shift_win) begin
                r_win_a <= i_win_a;
                r_win_b <= i_win_b;
            end
            if (i_ctrl.shift_rot) begin
                r_rot <= i_rot;
            end
        end
    end

    assign o_line_a = r_line_a;
    assign o_line_b = r_line_b;
    assign o_win_a  = r_win_a;
    assign o_win_b  = r_win_b;
    assign o_rot    = r_rot;

endmodule

// ===== rtl/fcb_mac.sv =====
// Multiply-accumulate unit at the head of the tap chain, with gain, rounding
// and saturation of the finished sum. Depends on fcb_pkg.
module fcb_mac #(
    parameter int TAPS = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_clear,
    input  logic                 i_issue,
    input  logic signed [15:0]   i_coef,
    input  logic signed [15:0]   i_sample,
    input  logic [15:0]          i_scale,
    output fcb_pkg::t_out_req    o_result
);
    import fcb_pkg::*;

    localparam int ACC_W = SCALED_W + $clog2(TAPS) + 1;
    localparam int Q_W   = ACC_W - OUT_SHIFT;

    localparam logic signed [ACC_W-1:0] RND_HALF =
        {{(ACC_W - OUT_SHIFT){1'b0}}, 1'b1, {(OUT_SHIFT - 1){1'b0}}};

    logic signed [PROD_W-1:0]   r_p1;
    logic signed [SCALED_W-1:0] r_p2;
    logic                       r_v1;
    logic                       r_v2;
    logic signed [ACC_W-1:0]    r_acc;

    logic signed [ACC_W-1:0]    rnd;
    logic signed [Q_W-1:0]      q;
    logic                       in_range;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_issue;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1 <= i_coef * i_sample;
        r_p2 <= r_p1 * $signed({1'b0, i_scale});
        if (i_clear) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + ACC_W'(r_p2);
        end
    end

    always_comb begin
        rnd      = r_acc + RND_HALF;
        q        = rnd[ACC_W-1:OUT_SHIFT];
        in_range = (&q[Q_W-1:DATA_W-1]) || !(|q[Q_W-1:DATA_W-1]);
        if (in_range) begin
            o_result.out_sample = q[DATA_W-1:0];
            o_result.saturated  = 1'b0;
        end else begin
            o_result.out_sample = q[Q_W-1] ? SAT_MIN : SAT_MAX;
            o_result.saturated  = 1'b1;
        end
    end

endmodule

// ===== rtl/fir_convolver_block_latency_top.sv =====
// Top level of the FIR convolver with one block of latency: controller, tap
// cell chain and output register. Depends on fcb_pkg, fcb_cell and fcb_mac.
//
// Each output is the gained sum of h[k] times the input from L+k samples back,
// L being the tap count in use, rounded and saturated to 16 bits. A coefficient
// load is taken while idle; one to an index below TAPS also clears the sample
// history at once. For a fed sample, the sample window in the cell chain first
// shifts past L entries, then L terms pass one per cycle through the single
// multiply-accumulate unit at the head of the chain, its two-stage multiply is
// drained, and the output register is loaded once free; only then is the next
// request taken. A sample fed while disabled goes straight to the emit state and
// returns zero. The output register holds a finished result while the next
// request is taken. There is no clearing pass after reset.
module fir_convolver_block_latency_top #(
    parameter int TAPS = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  fcb_pkg::t_in_req                    i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output fcb_pkg::t_out_req                   o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [fcb_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [fcb_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import fcb_pkg::*;

    localparam int CNT_W = $clog2(TAPS + 1);
    localparam int CMP_W = (CNT_W > TAPCNT_W) ? CNT_W : TAPCNT_W;

    logic [TAPCNT_W-1:0] r_tap_count;
    logic [SCALE_W-1:0]  r_scale;
    logic                r_enable;

    t_state              r_state;
    t_state              n_state;
    logic [CNT_W-1:0]    r_cnt;
    logic [CNT_W-1:0]    n_cnt;
    logic                r_dis;
    logic                n_dis;
    t_out_req            r_out;
    logic                r_out_valid;

    logic                accept;
    logic                out_free;
    logic                out_load;
    logic                coef_wr;
    logic                mac_clear;
    logic                mac_issue;
    t_cell_ctrl          cell_ctrl;
    t_out_req            mac_result;

    logic [CMP_W-1:0]    tap_ext;
    logic [CMP_W-1:0]    eff_ext;
    logic [CNT_W-1:0]    last_cnt;

    logic signed [DATA_W-1:0] line_a [TAPS];
    logic signed [DATA_W-1:0] line_b [TAPS];
    logic signed [DATA_W-1:0] win_a  [TAPS];
    logic signed [DATA_W-1:0] win_b  [TAPS];
    logic signed [DATA_W-1:0] rot    [TAPS];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count <= TAP_COUNT_RST;
            r_scale     <= SCALE_RST;
            r_enable    <= ENABLE_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_TAP_COUNT:  r_tap_count <= i_cfg_data[TAPCNT_W-1:0];
                REG_SCALE_GAIN: r_scale     <= i_cfg_data[SCALE_W-1:0];
                REG_ENABLE:     r_enable    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        tap_ext = CMP_W'(r_tap_count);
        if (tap_ext == '0) begin
            eff_ext = CMP_W'(1);
        end else if (tap_ext > CMP_W'(TAPS)) begin
            eff_ext = CMP_W'(TAPS);
        end else begin
            eff_ext = tap_ext;
        end
        last_cnt = eff_ext[CNT_W-1:0] - CNT_W'(1);
    end

    assign o_in_stall = (r_state != ST_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign out_free   = !(r_out_valid && i_out_stall);
    assign coef_wr    = accept && (i_in_data.opcode == OP_LOAD)
                        && (32'(i_in_data.coef_index) < TAPS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_dis   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_dis   <= n_dis;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_dis     = r_dis;
        cell_ctrl = '0;
        mac_clear = 1'b0;
        mac_issue = 1'b0;
        out_load  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_in_data.opcode == OP_LOAD) begin
                        cell_ctrl.clear_line = coef_wr;
                    end else if (!r_enable) begin
                        n_dis   = 1'b1;
                        n_state = ST_EMIT;
                    end else begin
                        cell_ctrl.shift_line = 1'b1;
                        cell_ctrl.load_win   = 1'b1;
                        mac_clear            = 1'b1;
                        n_dis                = 1'b0;
                        n_cnt                = '0;
                        n_state              = ST_SKIP;
                    end
                end
            end
            ST_SKIP: begin
                cell_ctrl.shift_win = 1'b1;
                if (r_cnt == last_cnt) begin
                    n_cnt   = '0;
                    n_state = ST_MAC;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            ST_MAC: begin
                cell_ctrl.shift_win = 1'b1;
                cell_ctrl.shift_rot = 1'b1;
                mac_issue           = 1'b1;
                if (r_cnt == last_cnt) begin
                    n_cnt   = '0;
                    n_state = ST_DRAIN;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            ST_DRAIN: begin
                if (r_cnt == CNT_W'(1)) begin
                    n_cnt   = '0;
                    n_state = ST_EMIT;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= (r_out_valid && i_out_stall) || out_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= r_dis ? '0 : mac_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    for (genvar k = 0; k < TAPS; k++) begin : g_cell
        logic signed [DATA_W-1:0] in_line_a;
        logic signed [DATA_W-1:0] in_line_b;
        logic signed [DATA_W-1:0] in_win_a;
        logic signed [DATA_W-1:0] in_win_b;
        logic signed [DATA_W-1:0] in_rot;
        logic                     coef_we;

        if (k == 0) begin : g_first
            assign in_line_a = i_in_data.sample;
            assign in_line_b = line_a[TAPS-1];
        end else begin : g_inner
            assign in_line_a = line_a[k-1];
            assign in_line_b = line_b[k-1];
        end

        if (k == TAPS - 1) begin : g_last
            assign in_win_a = win_b[0];
            assign in_win_b = '0;
            assign in_rot   = '0;
        end else begin : g_mid
            assign in_win_a = win_a[k+1];
            assign in_win_b = win_b[k+1];
            assign in_rot   = rot[k+1];
        end

        assign coef_we = coef_wr && (32'(i_in_data.coef_index) == k);

        fcb_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (cell_ctrl),
            .i_coef_we    (coef_we),
            .i_coef_value (i_in_data.coef_value),
            .i_line_a     (in_line_a),
            .i_line_b     (in_line_b),
            .i_win_a      (in_win_a),
            .i_win_b      (in_win_b),
            .i_rot        (in_rot),
            .o_line_a     (line_a[k]),
            .o_line_b     (line_b[k]),
            .o_win_a      (win_a[k]),
            .o_win_b      (win_b[k]),
            .o_rot        (rot[k])
        );
    end

    fcb_mac #(
        .TAPS (TAPS)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (mac_clear),
        .i_issue  (mac_issue),
        .i_coef   (rot[0]),
        .i_sample (win_a[0]),
        .i_scale  (r_scale),
        .o_result (mac_result)
    );

endmodule
